[sv/psz_pkg.sv]
`default_nettype none

package psz_pkg;

	localparam logic CMD_PLOT = 1'b0;
	localparam logic CMD_READ = 1'b1;
	localparam logic [2:0] FACE_MAX = 3'd5;

	localparam int CAM_Z_Q14 = 52429;
	localparam int NEAR_Z_Q14 = 4096;
	localparam int FACE_BIAS_Q28 = 2684;
	localparam logic signed [17:0] LIGHT_X = -18'sd4995;
	localparam logic signed [17:0] LIGHT_Y = 18'sd9990;
	localparam logic signed [17:0] LIGHT_Z = 18'sd11987;

	typedef enum logic [2:0] {
		CFG_SIN_X,
		CFG_COS_X,
		CFG_SIN_Y,
		CFG_COS_Y,
		CFG_SIN_Z,
		CFG_COS_Z,
		CFG_CUBE_SCALE,
		CFG_FOCAL_Y
	} cfg_idx_t;

	typedef struct packed {
		logic cmd;
		logic [2:0] face_index;
		logic signed [15:0] u_coord;
		logic signed [15:0] v_coord;
		logic [12:0] pixel_addr;
	} req_t;

	typedef struct packed {
		logic pixel_covered;
		logic [3:0] shade_level;
		logic [2:0] face_id;
	} rsp_t;

	typedef struct packed {
		logic [15:0] depth;
		logic covered;
		logic [3:0] shade;
		logic [2:0] face;
	} entry_t;

endpackage

`default_nettype wire

[sv/point_splat_zbuffer_renderer.sv]
// channel   | handshake              | payload
// request   | start / busy           | req (cmd, face_index, u_coord, v_coord, pixel_addr)
// result    | done, one-cycle strobe | rsp (pixel_covered, shade_level, face_id)
// config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// a read does one pixel-memory read, then the result strobe and clear
// a plot keeps busy high while one shared multiply-accumulate unit runs the
// rotations, scaling, projection and shading, and one radix-2 divider computes
// each of column, row and inverse depth
// after reset a clearing pass writes SCREEN_W*SCREEN_H entries, one a cycle,
// with busy high; config writes are taken at any time
// results are never held off by the receiver
`default_nettype none

module point_splat_zbuffer_renderer
	import psz_pkg::*;
#(
	parameter int SCREEN_W = 128,
	parameter int SCREEN_H = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	input  wire req_t req,
	output logic done,
	output rsp_t rsp,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [2:0] cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int PIXELS = SCREEN_W * SCREEN_H;
	localparam int AW = $clog2(PIXELS);
	localparam int CW = $clog2(SCREEN_W);
	localparam int RW = $clog2(SCREEN_H);
	localparam logic signed [17:0] FOCAL_X = 18'((SCREEN_W * 1536 + 5) / 10);
	localparam logic signed [17:0] COL_K = 18'(SCREEN_W * 128);
	localparam logic signed [17:0] ROW_K = 18'(SCREEN_H * 128);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_NROT, S_NCHK, S_SCALE, S_PROT, S_ZCHK, S_COLM,
		S_ROWM, S_DIV, S_DIVEND, S_LAM, S_SHADE, S_MEMRD, S_MEMWR, S_RDOUT
	} state_t;

	typedef enum logic [1:0] {DK_COL, DK_ROW, DK_INV} div_kind_t;

	state_t state_q;
	div_kind_t div_kind_q;
	logic [3:0] step_q;
	logic [5:0] cnt_q;
	logic [AW-1:0] clr_q, idx_q, rd_addr_q;
	logic rd_ok_q, neg_q, done_q;
	rsp_t rsp_q;
	logic [2:0] face_q;
	logic signed [15:0] u_q, v_q;
	logic signed [26:0] rx_q, ry_q, rz_q, nx_q, ny_q, nz_q, tmp_q, z_q;
	logic signed [47:0] acc_q;
	logic [47:0] dvd_q;
	logic [34:0] dvs_q, rem_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [15:0] inv_q;
	logic [3:0] level_q;

	logic signed [15:0] sin_x_q, cos_x_q, sin_y_q, cos_y_q, sin_z_q, cos_z_q;
	logic [14:0] cube_scale_q;
	logic [15:0] focal_y_q;

	entry_t mem [PIXELS];
	entry_t mem_rd_q, mem_wd;
	logic mem_we, mem_re;
	logic [AW-1:0] mem_wa, mem_ra;

	// multiply-accumulate
	logic [1:0] rot, sub;
	logic signed [26:0] ri, rj, opnd;
	logic signed [15:0] rc;
	logic signed [16:0] rs;
	logic signed [17:0] coef;
	logic first;
	logic signed [44:0] prod;
	logic signed [47:0] acc_next, rnd14_w, rnd12_w;
	logic signed [26:0] rnd14, rnd12;

	assign rot = step_q[3:2];
	assign sub = step_q[1:0];

	always_comb begin
		case (rot)
			2'd0: begin
				ri = rx_q; rj = ry_q; rc = cos_z_q; rs = 17'(sin_z_q);
			end
			2'd1: begin
				ri = ry_q; rj = rz_q; rc = cos_x_q; rs = 17'(sin_x_q);
			end
			default: begin
				ri = rx_q; rj = rz_q; rc = cos_y_q; rs = -17'(sin_y_q);
			end
		endcase
	end

	always_comb begin
		coef = '0;
		opnd = '0;
		first = 1'b0;
		case (state_q)
			S_NROT, S_PROT: begin
				case (sub)
					2'd0: begin coef = 18'(rc); opnd = ri; first = 1'b1; end
					2'd1: begin coef = -18'(rs); opnd = rj; end
					2'd2: begin coef = 18'(rs); opnd = ri; first = 1'b1; end
					default: begin coef = 18'(rc); opnd = rj; end
				endcase
			end
			S_SCALE: begin
				coef = 18'({1'b0, cube_scale_q});
				first = 1'b1;
				case (step_q)
					4'd0: opnd = rx_q;
					4'd1: opnd = ry_q;
					default: opnd = rz_q;
				endcase
			end
			S_COLM: begin
				if (step_q == 4'd0) begin
					coef = FOCAL_X; opnd = rx_q; first = 1'b1;
				end else begin
					coef = COL_K; opnd = z_q;
				end
			end
			S_ROWM: begin
				if (step_q == 4'd0) begin
					coef = -18'({1'b0, focal_y_q}); opnd = ry_q; first = 1'b1;
				end else begin
					coef = ROW_K; opnd = z_q;
				end
			end
			S_LAM: begin
				case (step_q)
					4'd0: begin coef = LIGHT_X; opnd = nx_q; first = 1'b1; end
					4'd1: begin coef = LIGHT_Y; opnd = ny_q; end
					default: begin coef = LIGHT_Z; opnd = nz_q; end
				endcase
			end
			default: ;
		endcase
	end

	assign prod = coef * opnd;
	assign acc_next = (first ? 48'sd0 : acc_q) + 48'(prod);
	assign rnd14_w = (acc_next + 48'sd8192) >>> 14;
	assign rnd12_w = (acc_next + 48'sd2048) >>> 12;
	assign rnd14 = rnd14_w[26:0];
	assign rnd12 = rnd12_w[26:0];

	// divider step
	logic [35:0] rem_sh, rem_diff;
	logic div_ge;
	assign rem_sh = {rem_q, dvd_q[47]};
	assign rem_diff = rem_sh - {1'b0, dvs_q};
	assign div_ge = rem_sh >= {1'b0, dvs_q};

	// projection bounds, inverse depth
	logic proj_ok;
	logic [48:0] inv_sum;
	logic [15:0] inv_sat;
	assign proj_ok = neg_q ? (dvd_q == 48'd0)
		: ((div_kind_q == DK_COL) ? (dvd_q < 48'(SCREEN_W)) : (dvd_q < 48'(SCREEN_H)));
	assign inv_sum = 49'(dvd_q) + 49'(face_q) * 49'(FACE_BIAS_Q28) + 49'd8192;
	assign inv_sat = (|inv_sum[48:30]) ? 16'hFFFF : inv_sum[29:14];

	// shade level
	logic [30:0] s_val;
	logic [37:0] m_val;
	logic [7:0] q8;
	logic [3:0] lvl;
	always_comb begin
		if (acc_q[47])
			s_val = 31'h1000_0000;
		else if (|acc_q[46:28])
			s_val = 31'h4000_0000;
		else
			s_val = 31'h1000_0000 + 31'(acc_q[27:0]) * 31'd3;
		m_val = face_q[0] ? 38'(s_val) * 38'd108 : 38'(s_val) * 38'd72;
		q8 = m_val[37:30];
		lvl = '0;
		for (int l = 1; l <= 9; l++) begin
			if (q8 >= 8'(10 * l - 5))
				lvl = lvl + 4'd1;
		end
	end

	logic signed [27:0] zsum;
	logic rd_in_range;
	logic [1:0] axis;
	logic signed [26:0] sgn;
	assign zsum = 28'(rz_q) + 28'(CAM_Z_Q14);
	assign rd_in_range = 32'(req.pixel_addr) < 32'(PIXELS);
	assign axis = req.face_index[2:1];
	assign sgn = face_q[0] ? -27'sd16384 : 27'sd16384;

	logic signed [26:0] nsgn;
	assign nsgn = req.face_index[0] ? -27'sd16384 : 27'sd16384;

	// pixel memory port control
	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_q;
		mem_wd = '0;
		mem_re = 1'b0;
		mem_ra = idx_q;
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
			end
			S_IDLE: begin
				mem_re = start;
				mem_ra = AW'(req.pixel_addr);
			end
			S_RDOUT: begin
				mem_we = rd_ok_q;
				mem_wa = rd_addr_q;
			end
			S_MEMRD: mem_re = 1'b1;
			S_MEMWR: begin
				mem_we = inv_q > mem_rd_q.depth;
				mem_wd = '{depth: inv_q, covered: 1'b1, shade: level_q, face: face_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (mem_re)
			mem_rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sin_x_q <= '0;
			cos_x_q <= 16'sd16384;
			sin_y_q <= '0;
			cos_y_q <= 16'sd16384;
			sin_z_q <= '0;
			cos_z_q <= 16'sd16384;
			cube_scale_q <= 15'd4096;
			focal_y_q <= 16'd9830;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SIN_X: sin_x_q <= cfg_data;
				CFG_COS_X: cos_x_q <= cfg_data;
				CFG_SIN_Y: sin_y_q <= cfg_data;
				CFG_COS_Y: cos_y_q <= cfg_data;
				CFG_SIN_Z: sin_z_q <= cfg_data;
				CFG_COS_Z: cos_z_q <= cfg_data;
				CFG_CUBE_SCALE: cube_scale_q <= cfg_data[14:0];
				CFG_FOCAL_Y: focal_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			div_kind_q <= DK_COL;
			step_q <= '0;
			cnt_q <= '0;
			clr_q <= '0;
			idx_q <= '0;
			rd_addr_q <= '0;
			rd_ok_q <= 1'b0;
			neg_q <= 1'b0;
			done_q <= 1'b0;
			rsp_q <= '0;
			face_q <= '0;
			u_q <= '0;
			v_q <= '0;
			rx_q <= '0;
			ry_q <= '0;
			rz_q <= '0;
			nx_q <= '0;
			ny_q <= '0;
			nz_q <= '0;
			tmp_q <= '0;
			z_q <= '0;
			acc_q <= '0;
			dvd_q <= '0;
			dvs_q <= '0;
			rem_q <= '0;
			col_q <= '0;
			row_q <= '0;
			inv_q <= '0;
			level_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(PIXELS - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						if (req.cmd == CMD_READ) begin
							rd_addr_q <= AW'(req.pixel_addr);
							rd_ok_q <= rd_in_range;
							state_q <= S_RDOUT;
						end else if (req.face_index <= FACE_MAX) begin
							face_q <= req.face_index;
							u_q <= req.u_coord;
							v_q <= req.v_coord;
							rx_q <= (axis == 2'd0) ? nsgn : 27'sd0;
							ry_q <= (axis == 2'd1) ? nsgn : 27'sd0;
							rz_q <= (axis == 2'd2) ? nsgn : 27'sd0;
							step_q <= '0;
							state_q <= S_NROT;
						end
					end
				end
				S_RDOUT: begin
					rsp_q <= rd_ok_q ? rsp_t'{pixel_covered: mem_rd_q.covered,
						shade_level: mem_rd_q.shade, face_id: mem_rd_q.face} : '0;
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_NROT, S_PROT: begin
					acc_q <= acc_next;
					if (sub == 2'd1)
						tmp_q <= rnd14;
					if (sub == 2'd3) begin
						case (rot)
							2'd0: begin rx_q <= tmp_q; ry_q <= rnd14; end
							2'd1: begin ry_q <= tmp_q; rz_q <= rnd14; end
							default: begin rx_q <= tmp_q; rz_q <= rnd14; end
						endcase
					end
					step_q <= step_q + 4'd1;
					if (step_q == 4'd11) begin
						step_q <= '0;
						state_q <= (state_q == S_NROT) ? S_NCHK : S_ZCHK;
					end
				end
				S_NCHK: begin
					if (!rz_q[26]) begin
						state_q <= S_IDLE;
					end else begin
						nx_q <= rx_q;
						ny_q <= ry_q;
						nz_q <= rz_q;
						case (face_q[2:1])
							2'd0: begin
								rx_q <= sgn; ry_q <= 27'(u_q); rz_q <= 27'(v_q);
							end
							2'd1: begin
								rx_q <= 27'(u_q); ry_q <= sgn; rz_q <= 27'(v_q);
							end
							default: begin
								rx_q <= 27'(u_q); ry_q <= 27'(v_q); rz_q <= sgn;
							end
						endcase
						step_q <= '0;
						state_q <= S_SCALE;
					end
				end
				S_SCALE: begin
					case (step_q)
						4'd0: rx_q <= rnd12;
						4'd1: ry_q <= rnd12;
						default: rz_q <= rnd12;
					endcase
					step_q <= step_q + 4'd1;
					if (step_q == 4'd2) begin
						step_q <= '0;
						state_q <= S_PROT;
					end
				end
				S_ZCHK: begin
					if (zsum <= 28'(NEAR_Z_Q14)) begin
						state_q <= S_IDLE;
					end else begin
						z_q <= zsum[26:0];
						step_q <= '0;
						state_q <= S_COLM;
					end
				end
				S_COLM, S_ROWM: begin
					if (step_q == 4'd0) begin
						acc_q <= acc_next;
						step_q <= 4'd1;
					end else begin
						step_q <= '0;
						neg_q <= acc_next[47];
						dvd_q <= acc_next[47] ? 48'(-acc_next) : 48'(acc_next);
						dvs_q <= {z_q, 8'h00};
						rem_q <= '0;
						cnt_q <= '0;
						div_kind_q <= (state_q == S_COLM) ? DK_COL : DK_ROW;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= div_ge ? rem_diff[34:0] : rem_sh[34:0];
					dvd_q <= {dvd_q[46:0], div_ge};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd47)
						state_q <= S_DIVEND;
				end
				S_DIVEND: begin
					case (div_kind_q)
						DK_COL: begin
							col_q <= CW'(dvd_q);
							state_q <= proj_ok ? S_ROWM : S_IDLE;
						end
						DK_ROW: begin
							row_q <= RW'(dvd_q);
							if (proj_ok) begin
								dvd_q <= 48'h400_0000_0000;
								dvs_q <= 35'({8'h00, z_q});
								rem_q <= '0;
								cnt_q <= '0;
								neg_q <= 1'b0;
								div_kind_q <= DK_INV;
								state_q <= S_DIV;
							end else begin
								state_q <= S_IDLE;
							end
						end
						default: begin
							inv_q <= inv_sat;
							step_q <= '0;
							state_q <= S_LAM;
						end
					endcase
				end
				S_LAM: begin
					acc_q <= acc_next;
					step_q <= step_q + 4'd1;
					if (step_q == 4'd2) begin
						step_q <= '0;
						state_q <= S_SHADE;
					end
				end
				S_SHADE: begin
					level_q <= lvl;
					idx_q <= AW'(32'(row_q) * 32'(SCREEN_W) + 32'(col_q));
					state_q <= S_MEMRD;
				end
				S_MEMRD: state_q <= S_MEMWR;
				S_MEMWR: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign rsp = rsp_q;
	assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

[sv/psz_checker.sv]
`default_nettype none

module psz_checker
	import psz_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire req_t req,
	input wire logic done,
	input wire rsp_t rsp
);

	logic rd_req, plot_req;
	assign rd_req = start && !busy && req.cmd == CMD_READ;
	assign plot_req = start && !busy && req.cmd == CMD_PLOT;

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		rd_req |=> busy ##1 done)
		else $error("read request without result");

	a_plot_silent: assert property (@(posedge clk) disable iff (!arst_n)
		plot_req |=> !done)
		else $error("result after plot request");

	a_no_stray: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without request");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.shade_level <= 4'd9 && rsp.face_id <= FACE_MAX))
		else $error("result field out of range");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.pixel_covered) |-> (rsp.shade_level == 4'd0 && rsp.face_id == 3'd0))
		else $error("uncovered pixel with data");

endmodule

bind point_splat_zbuffer_renderer psz_checker u_psz_checker (.*);

`default_nettype wire

[dv/tb_point_splat_zbuffer_renderer.sv]
`timescale 1ns / 1ps

module tb_point_splat_zbuffer_renderer;
	import psz_pkg::*;

	localparam int SCREEN_W = 128;
	localparam int SCREEN_H = 64;
	localparam int PIXELS = SCREEN_W * SCREEN_H;
	localparam longint FOCAL_X = (SCREEN_W * 1536 + 5) / 10;
	localparam int IDLE_PAUSE = 260;
	localparam int STALL_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;

	point_splat_zbuffer_renderer #(
		.SCREEN_W(SCREEN_W),
		.SCREEN_H(SCREEN_H)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// view and scale settings of the predictor
	longint sx, cx, sy, cy, sz, cz, scale_q12, focal_q8;
	// predicted frame buffer
	logic [15:0] zbuf_depth [PIXELS];
	logic [3:0] zbuf_shade [PIXELS];
	logic [2:0] zbuf_face [PIXELS];
	logic zbuf_covered [PIXELS];

	rsp_t pending_pixels [$];
	int drawn_addrs [$];
	int errors;
	int stall_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint rnd14(longint x);
		return (x + 8192) >>> 14;
	endfunction

	function automatic void rotate_vec(inout longint x, inout longint y, inout longint z);
		longint t;
		t = rnd14(cz * x - sz * y);
		y = rnd14(sz * x + cz * y);
		x = t;
		t = rnd14(cx * y - sx * z);
		z = rnd14(sx * y + cx * z);
		y = t;
		t = rnd14(cy * x + sy * z);
		z = rnd14(-sy * x + cy * z);
		x = t;
	endfunction

	function automatic void splat_point(logic [2:0] face, longint u, longint v);
		longint n [3];
		longint p [3];
		longint sgn, z, col, row, lam, s, k, num, den, level, r28, inv;
		int axis, idx;
		if (face > FACE_MAX)
			return;
		sgn = face[0] ? -16384 : 16384;
		axis = int'(face[2:1]);
		n[0] = 0;
		n[1] = 0;
		n[2] = 0;
		n[axis] = sgn;
		rotate_vec(n[0], n[1], n[2]);
		if (n[2] >= 0)
			return;
		if (axis == 0) begin
			p[0] = sgn; p[1] = u; p[2] = v;
		end else if (axis == 1) begin
			p[0] = u; p[1] = sgn; p[2] = v;
		end else begin
			p[0] = u; p[1] = v; p[2] = sgn;
		end
		for (int i = 0; i < 3; i++)
			p[i] = (p[i] * scale_q12 + 2048) >>> 12;
		rotate_vec(p[0], p[1], p[2]);
		z = p[2] + CAM_Z_Q14;
		if (z <= NEAR_Z_Q14)
			return;
		col = (p[0] * FOCAL_X + longint'(SCREEN_W) * 128 * z) / (256 * z);
		row = (-p[1] * focal_q8 + longint'(SCREEN_H) * 128 * z) / (256 * z);
		if (col < 0 || col >= SCREEN_W || row < 0 || row >= SCREEN_H)
			return;
		r28 = (longint'(1) << 42) / z;
		inv = (r28 + longint'(face) * FACE_BIAS_Q28 + 8192) >>> 14;
		if (inv > 65535)
			inv = 65535;
		idx = int'(row * SCREEN_W + col);
		if (inv <= zbuf_depth[idx])
			return;
		lam = n[0] * LIGHT_X + n[1] * LIGHT_Y + n[2] * LIGHT_Z;
		if (lam < 0)
			lam = 0;
		s = (longint'(1) << 28) + 3 * lam;
		if (s > (longint'(1) << 30))
			s = longint'(1) << 30;
		k = face[0] ? 6 : 4;
		num = s * k * 9;
		den = 5 * (longint'(1) << 30);
		level = (2 * num + den) / (2 * den);
		if (level > 9)
			level = 9;
		zbuf_depth[idx] = inv[15:0];
		zbuf_shade[idx] = level[3:0];
		zbuf_face[idx] = face;
		zbuf_covered[idx] = 1'b1;
		drawn_addrs.push_back(idx);
	endfunction

	function automatic void fetch_pixel(logic [12:0] addr);
		rsp_t r;
		r = '0;
		if (addr < PIXELS) begin
			r.pixel_covered = zbuf_covered[addr];
			r.shade_level = zbuf_shade[addr];
			r.face_id = zbuf_face[addr];
			zbuf_depth[addr] = '0;
			zbuf_shade[addr] = '0;
			zbuf_face[addr] = '0;
			zbuf_covered[addr] = 1'b0;
		end
		pending_pixels.push_back(r);
	endfunction

	task automatic report_mismatch(string what);
		errors++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch("pixel result with no read pending");
			end else begin
				rsp_t e;
				e = pending_pixels.pop_front();
				if (rsp.pixel_covered !== e.pixel_covered)
					report_mismatch($sformatf("covered %b exp %b", rsp.pixel_covered,
						e.pixel_covered));
				if (rsp.shade_level !== e.shade_level)
					report_mismatch($sformatf("shade %0d exp %0d", rsp.shade_level,
						e.shade_level));
				if (rsp.face_id !== e.face_id)
					report_mismatch($sformatf("face %0d exp %0d", rsp.face_id, e.face_id));
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			stall_count <= 0;
		else
			stall_count <= stall_count + 1;
		if (stall_count >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic random_gap();
		int n;
		n = $urandom_range(0, 99);
		if (n < 60)
			n = 0;
		else if (n < 94)
			n = $urandom_range(1, 4);
		else
			n = $urandom_range(20, 80);
		repeat (n) @(negedge clk);
	endtask

	task automatic send_request(req_t r);
		start = 1'b1;
		req = r;
		do @(posedge clk); while (busy);
		if (r.cmd == CMD_READ)
			fetch_pixel(r.pixel_addr);
		else
			splat_point(r.face_index, longint'(r.u_coord), longint'(r.v_coord));
		@(negedge clk);
		if ($urandom_range(0, 3) != 0) begin
			start = 1'b0;
			random_gap();
		end
	endtask

	task automatic plot(logic [2:0] f, logic signed [15:0] u, logic signed [15:0] v);
		req_t r;
		r = '0;
		r.cmd = CMD_PLOT;
		r.face_index = f;
		r.u_coord = u;
		r.v_coord = v;
		r.pixel_addr = 13'($urandom);
		send_request(r);
	endtask

	task automatic read_pixel(logic [12:0] a);
		req_t r;
		r = req_t'(49'({$urandom, $urandom}));
		r.cmd = CMD_READ;
		r.pixel_addr = a;
		send_request(r);
	endtask

	task automatic wait_idle();
		start = 1'b0;
		do @(posedge clk); while (pending_pixels.size() != 0 || busy);
		repeat (IDLE_PAUSE) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_cfg(cfg_idx_t idx, logic [15:0] d);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = d;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_SIN_X: sx = longint'($signed(d));
			CFG_COS_X: cx = longint'($signed(d));
			CFG_SIN_Y: sy = longint'($signed(d));
			CFG_COS_Y: cy = longint'($signed(d));
			CFG_SIN_Z: sz = longint'($signed(d));
			CFG_COS_Z: cz = longint'($signed(d));
			CFG_CUBE_SCALE: scale_q12 = longint'(d[14:0]);
			CFG_FOCAL_Y: focal_q8 = longint'(d);
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_view(logic [15:0] s_x, logic [15:0] c_x, logic [15:0] s_y,
		logic [15:0] c_y, logic [15:0] s_z, logic [15:0] c_z, logic [15:0] scl,
		logic [15:0] fy);
		wait_idle();
		write_cfg(CFG_SIN_X, s_x);
		write_cfg(CFG_COS_X, c_x);
		write_cfg(CFG_SIN_Y, s_y);
		write_cfg(CFG_COS_Y, c_y);
		write_cfg(CFG_SIN_Z, s_z);
		write_cfg(CFG_COS_Z, c_z);
		write_cfg(CFG_CUBE_SCALE, scl);
		write_cfg(CFG_FOCAL_Y, fy);
	endtask

	function automatic logic [31:0] angle_pair();
		logic signed [15:0] s, c, t;
		case ($urandom_range(0, 4))
			0: begin s = 0; c = 16384; end
			1: begin s = 8192; c = 14189; end
			2: begin s = 11585; c = 11585; end
			3: begin s = 14189; c = 8192; end
			default: begin s = 16384; c = 0; end
		endcase
		if ($urandom_range(0, 1)) begin
			t = s; s = c; c = t;
		end
		if ($urandom_range(0, 1))
			s = -s;
		if ($urandom_range(0, 1))
			c = -c;
		return {s, c};
	endfunction

	task automatic random_view();
		logic [31:0] ax, ay, az;
		ax = angle_pair();
		ay = angle_pair();
		az = angle_pair();
		if ($urandom_range(0, 5) == 0)
			ax = $urandom;
		set_view(ax[31:16], ax[15:0], ay[31:16], ay[15:0], az[31:16], az[15:0],
			16'($urandom_range(410, 8192)),
			($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(4000, 16000)));
	endtask

	task automatic read_back_drawn();
		while (drawn_addrs.size() != 0)
			read_pixel(13'(drawn_addrs.pop_front()));
	endtask

	task automatic test_reset_state();
		read_pixel(13'd0);
		read_pixel(13'(PIXELS - 1));
		read_pixel(13'd4160);
	endtask

	task automatic test_directed_points();
		plot(3'd5, 16'sd0, 16'sd0);
		plot(3'd5, 16'sd0, 16'sd0);
		plot(3'd5, 16'sd16384, 16'sd16384);
		plot(3'd5, -16'sd16384, -16'sd16384);
		plot(3'd5, 16'sd16384, -16'sd16384);
		plot(3'd5, -16'sh8000, 16'sh7fff);
		for (int f = 0; f < 8; f++)
			plot(3'(f), 16'sd4000, -16'sd4000);
		read_back_drawn();
		read_pixel(13'd4160);
	endtask

	task automatic test_config_extremes();
		set_view(16'h0000, 16'h4000, 16'h0000, 16'h4000, 16'h0000, 16'h4000, 16'd16384,
			16'd0);
		plot(3'd5, 16'sd0, 16'sd0);
		set_view(16'hc000, 16'h0000, 16'h4000, 16'h0000, 16'hc000, 16'h0000, 16'd410,
			16'd65535);
		for (int f = 0; f < 6; f++)
			plot(3'(f), 16'sd9000, -16'sd9000);
		read_back_drawn();
	endtask

	task automatic test_random_frames();
		req_t r;
		for (int ph = 0; ph < 5; ph++) begin
			random_view();
			for (int i = 0; i < 110; i++) begin
				if ($urandom_range(0, 9) < 6) begin
					r = req_t'(49'({$urandom, $urandom}));
					r.cmd = CMD_PLOT;
					if ($urandom_range(0, 9) != 0) begin
						r.face_index = 3'($urandom_range(0, 5));
						r.u_coord = 16'($signed($urandom_range(0, 32768)) - 16384);
						r.v_coord = 16'($signed($urandom_range(0, 32768)) - 16384);
					end
					send_request(r);
				end else if (drawn_addrs.size() != 0 && $urandom_range(0, 3) != 0) begin
					read_pixel(13'(drawn_addrs[$urandom_range(0, drawn_addrs.size() - 1)]));
				end else begin
					read_pixel(13'($urandom));
				end
			end
			read_back_drawn();
		end
	endtask

	initial begin
		errors = 0;
		stall_count = 0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sx = 0; cx = 16384; sy = 0; cy = 16384; sz = 0; cz = 16384;
		scale_q12 = 4096;
		focal_q8 = 9830;
		for (int i = 0; i < PIXELS; i++) begin
			zbuf_depth[i] = '0;
			zbuf_shade[i] = '0;
			zbuf_face[i] = '0;
			zbuf_covered[i] = 1'b0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_directed_points();
		test_config_extremes();
		test_random_frames();

		wait_idle();
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[point_splat_zbuffer_renderer.f]
sv/psz_pkg.sv
sv/point_splat_zbuffer_renderer.sv
sv/psz_checker.sv
dv/tb_point_splat_zbuffer_renderer.sv
